### design/tprc_pkg.sv
// Package for the TCP port rewrite and checksum core.
// Holds constants, the configuration index enum, the result struct and the fold helpers.
// No dependencies.
package tprc_pkg;

  localparam int unsigned MaxSegmentBytes = 65535;
  localparam int unsigned CountW          = $clog2(MaxSegmentBytes + 1);

  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [15:0] ProtoTcp     = 16'd6;
  localparam logic [31:0] LoopbackAddr = 32'h7F00_0001;

  // Header byte positions touched by the rewrite
  localparam logic [CountW-1:0] SrcHiPos  = CountW'(0);
  localparam logic [CountW-1:0] SrcLoPos  = CountW'(1);
  localparam logic [CountW-1:0] DstHiPos  = CountW'(2);
  localparam logic [CountW-1:0] DstLoPos  = CountW'(3);
  localparam logic [CountW-1:0] CsumHiPos = CountW'(16);
  localparam logic [CountW-1:0] CsumLoPos = CountW'(17);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NEW_SRC_PORT,
    CFG_NEW_DST_PORT,
    CFG_PSEUDO_SRC_ADDR,
    CFG_PSEUDO_DST_ADDR
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] tcp_checksum;
    logic        checksum_valid;
    logic        too_long;
  } result_t;

  // End-around carry fold of a sum of up to eight 16-bit words
  function automatic logic [15:0] fold19(input logic [18:0] t);
    logic [16:0] t1;
    t1 = {1'b0, t[15:0]} + {14'b0, t[18:16]};
    return t1[15:0] + {15'b0, t1[16]};
  endfunction

  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    return fold19({3'b0, a} + {3'b0, b});
  endfunction

  function automatic logic [15:0] pseudo_fold(input logic [31:0] src, input logic [31:0] dst);
    return fold19({3'b0, src[31:16]} + {3'b0, src[15:0]} +
                  {3'b0, dst[31:16]} + {3'b0, dst[15:0]} + {3'b0, ProtoTcp});
  endfunction

endpackage

### design/tprc_if.sv
// Valid/ready channel interfaces for the segment byte input and the result output.
// Depends on nothing.
interface tprc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] seg_byte;
  logic       is_last;

  modport source (output valid, output seg_byte, output is_last, input ready);
  modport sink   (input valid, input seg_byte, input is_last, output ready);
endinterface

interface tprc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] tcp_checksum;
  logic        checksum_valid;
  logic        too_long;

  modport source (output valid, output out_byte, output out_last, output tcp_checksum,
                  output checksum_valid, output too_long, input ready);
  modport sink   (input valid, input out_byte, input out_last, input tcp_checksum,
                  input checksum_valid, input too_long, output ready);
endinterface

### design/tprc_pseudo_sum.sv
// Registered pseudo-header partial sum: both addresses plus the protocol number.
// Depends on tprc_pkg.
module tprc_pseudo_sum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  output logic [15:0] pseudo_sum_o
);

  logic [15:0] sum_q, sum_d;

  assign sum_d = tprc_pkg::pseudo_fold(src_addr_i, dst_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= tprc_pkg::pseudo_fold(tprc_pkg::LoopbackAddr, tprc_pkg::LoopbackAddr);
    end else begin
      sum_q <= sum_d;
    end
  end

  assign pseudo_sum_o = sum_q;

endmodule

### design/tprc_seg_engine.sv
// Per-segment engine: port substitution, checksum field zeroing, running sum and
// final checksum. Depends on tprc_pkg.
module tprc_seg_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [7:0]                seg_byte_i,
  input  logic                      is_last_i,
  input  logic [15:0]               new_src_port_i,
  input  logic [15:0]               new_dst_port_i,
  input  logic [15:0]               pseudo_sum_i,
  output tprc_pkg::result_t         res_o
);

  logic [tprc_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  hold_q, hold_d;
  logic        ovf_q, ovf_d;

  logic        rewrite, over, odd, ovf_now, valid;
  logic [7:0]  ob;
  logic [15:0] word;
  logic [18:0] total;

  always_comb begin
    rewrite   = (|new_src_port_i) | (|new_dst_port_i);
    over      = (count_q == tprc_pkg::CountW'(tprc_pkg::MaxSegmentBytes));
    odd       = count_q[0];
    count_inc = count_q + tprc_pkg::CountW'(1);

    ob = seg_byte_i;
    if (!over && rewrite) begin
      priority if (count_q == tprc_pkg::SrcHiPos && (|new_src_port_i)) begin
        ob = new_src_port_i[15:8];
      end else if (count_q == tprc_pkg::SrcLoPos && (|new_src_port_i)) begin
        ob = new_src_port_i[7:0];
      end else if (count_q == tprc_pkg::DstHiPos && (|new_dst_port_i)) begin
        ob = new_dst_port_i[15:8];
      end else if (count_q == tprc_pkg::DstLoPos && (|new_dst_port_i)) begin
        ob = new_dst_port_i[7:0];
      end else if (count_q == tprc_pkg::CsumHiPos || count_q == tprc_pkg::CsumLoPos) begin
        ob = 8'h00;
      end
    end

    // even position: trailing odd byte padded as the high byte of a word
    word = odd ? {hold_q, ob} : {ob, 8'h00};

    total = {3'b0, acc_q} + {3'b0, word} + {3'b0, pseudo_sum_i} + 19'(count_inc);

    ovf_now = ovf_q | over;
    valid   = is_last_i & rewrite & ~ovf_now;

    res_o.out_byte       = ob;
    res_o.out_last       = is_last_i;
    res_o.tcp_checksum   = valid ? ~tprc_pkg::fold19(total) : 16'h0000;
    res_o.checksum_valid = valid;
    res_o.too_long       = ovf_now;
  end

  always_comb begin
    count_d = count_q;
    acc_d   = acc_q;
    hold_d  = hold_q;
    ovf_d   = ovf_now;
    if (!over) begin
      count_d = count_inc;
      hold_d  = odd ? hold_q : ob;
      acc_d   = odd ? tprc_pkg::oc_add(acc_q, word) : acc_q;
    end
    if (is_last_i) begin
      count_d = '0;
      acc_d   = '0;
      hold_d  = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      acc_q   <= '0;
      hold_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (fire_i) begin
      count_q <= count_d;
      acc_q   <= acc_d;
      hold_q  <= hold_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### design/tcp_port_rewrite_checksum_core.sv
// Top level of the TCP port rewrite and checksum core.
// Depends on tprc_pkg, tprc_if, tprc_pseudo_sum and tprc_seg_engine.

// One segment byte is taken per cycle and one result per byte comes out, back to back
// with no bubbles while the receiver keeps ready high; a result stall holds the input.
// Each byte goes through the input register and then the result register. The input
// register feeds the segment engine, whose substitution, running sum and final
// checksum add sit combinationally between the input and the result register. The
// pseudo-header address sum is kept precomputed from the register writes, so the
// checksum on the last byte costs a single fold. Ports and addresses must be written
// only while no segment byte is in flight.
module tcp_port_rewrite_checksum_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tprc_in_if.sink                        seg_i,
  tprc_out_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [tprc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tprc_pkg::CfgW-1:0]      cfg_wdata_i
);

  logic [15:0] new_src_port_q, new_dst_port_q;
  logic [31:0] src_addr_q, dst_addr_q;
  logic [31:0] src_addr_d, dst_addr_d;
  logic [15:0] pseudo_sum;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q;
  tprc_pkg::result_t out_q, res_d;

  logic adv, fire, in_xfer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      new_src_port_q <= '0;
      new_dst_port_q <= '0;
      src_addr_q     <= tprc_pkg::LoopbackAddr;
      dst_addr_q     <= tprc_pkg::LoopbackAddr;
    end else if (cfg_we_i) begin
      unique case (tprc_pkg::cfg_idx_e'(cfg_idx_i))
        tprc_pkg::CFG_NEW_SRC_PORT:    new_src_port_q <= cfg_wdata_i[15:0];
        tprc_pkg::CFG_NEW_DST_PORT:    new_dst_port_q <= cfg_wdata_i[15:0];
        tprc_pkg::CFG_PSEUDO_SRC_ADDR: src_addr_q     <= cfg_wdata_i[31:0];
        tprc_pkg::CFG_PSEUDO_DST_ADDR: dst_addr_q     <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // next address values, so the pseudo sum updates at the same edge as the addresses
  assign src_addr_d = (cfg_we_i && tprc_pkg::cfg_idx_e'(cfg_idx_i) == tprc_pkg::CFG_PSEUDO_SRC_ADDR)
                      ? cfg_wdata_i[31:0] : src_addr_q;
  assign dst_addr_d = (cfg_we_i && tprc_pkg::cfg_idx_e'(cfg_idx_i) == tprc_pkg::CFG_PSEUDO_DST_ADDR)
                      ? cfg_wdata_i[31:0] : dst_addr_q;

  tprc_pseudo_sum u_pseudo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_addr_i   (src_addr_d),
    .dst_addr_i   (dst_addr_d),
    .pseudo_sum_o (pseudo_sum)
  );

  assign adv       = ~out_valid_q | res_o.ready;
  assign fire      = in_valid_q & adv;
  assign seg_i.ready = ~in_valid_q | adv;
  assign in_xfer   = seg_i.valid & seg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_byte_q <= seg_i.seg_byte;
      in_last_q <= seg_i.is_last;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  tprc_seg_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .seg_byte_i     (in_byte_q),
    .is_last_i      (in_last_q),
    .new_src_port_i (new_src_port_q),
    .new_dst_port_i (new_dst_port_q),
    .pseudo_sum_i   (pseudo_sum),
    .res_o          (res_d)
  );

  assign res_o.valid          = out_valid_q;
  assign res_o.out_byte       = out_q.out_byte;
  assign res_o.out_last       = out_q.out_last;
  assign res_o.tcp_checksum   = out_q.tcp_checksum;
  assign res_o.checksum_valid = out_q.checksum_valid;
  assign res_o.too_long       = out_q.too_long;

  a_csum_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.checksum_valid |-> out_q.out_last)
    else $error("checksum flagged on a byte that is not the last");

  a_csum_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.checksum_valid |-> out_q.tcp_checksum == 16'h0000)
    else $error("checksum nonzero without checksum_valid");

  a_csum_never_neg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.checksum_valid |-> out_q.tcp_checksum != 16'hFFFF)
    else $error("checksum fold produced negative zero");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q) && $stable(in_last_q))
    else $error("held input byte lost during output stall");

endmodule

### sim/tprc_checksum_checker.sv
// Result checker for the TCP port rewrite and checksum core.
// Watches the segment and result channels and the register write port, predicts the result
// of every segment byte transfer and counts mismatches. Depends on tprc_pkg and tprc_if.
module tprc_checksum_checker
  import tprc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  tprc_in_if                 seg_i,
  tprc_out_if                res_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  output int unsigned        mismatch_count_o,
  output int unsigned        in_flight_o
);

  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;

  logic [16:0] seg_count;
  logic [15:0] run_sum;
  logic [7:0]  hi_hold;
  logic        seg_overflow;

  result_t rewritten_q[$];
  result_t seen;
  result_t want;

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

  function automatic result_t rewrite_byte(input logic [7:0] b, input logic last);
    logic        swap;
    logic [7:0]  ob;
    logic [15:0] s;
    result_t     r;
    swap = (src_port != 16'h0) || (dst_port != 16'h0);
    ob   = b;
    r    = '0;
    if (seg_count >= 17'(MaxSegmentBytes)) begin
      seg_overflow = 1'b1;
    end else begin
      if (swap) begin
        case (seg_count)
          17'(SrcHiPos): if (src_port != 16'h0) ob = src_port[15:8];
          17'(SrcLoPos): if (src_port != 16'h0) ob = src_port[7:0];
          17'(DstHiPos): if (dst_port != 16'h0) ob = dst_port[15:8];
          17'(DstLoPos): if (dst_port != 16'h0) ob = dst_port[7:0];
          17'(CsumHiPos), 17'(CsumLoPos): ob = 8'h00;
          default: ;
        endcase
      end
      if (!seg_count[0])
        hi_hold = ob;
      else
        run_sum = fold_add(run_sum, {hi_hold, ob});
      seg_count = seg_count + 17'd1;
    end
    r.out_byte = ob;
    r.out_last = last;
    r.too_long = seg_overflow;
    if (last) begin
      if (swap && !seg_overflow) begin
        s = run_sum;
        // odd trailing byte is padded as the high half of a word
        if (seg_count[0]) s = fold_add(s, {hi_hold, 8'h00});
        s = fold_add(s, src_addr[31:16]);
        s = fold_add(s, src_addr[15:0]);
        s = fold_add(s, dst_addr[31:16]);
        s = fold_add(s, dst_addr[15:0]);
        s = fold_add(s, ProtoTcp);
        s = fold_add(s, seg_count[15:0]);
        r.tcp_checksum   = ~s;
        r.checksum_valid = 1'b1;
      end
      seg_count    = '0;
      run_sum      = '0;
      hi_hold      = '0;
      seg_overflow = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_port         = 16'h0;
      dst_port         = 16'h0;
      src_addr         = LoopbackAddr;
      dst_addr         = LoopbackAddr;
      seg_count        = '0;
      run_sum          = '0;
      hi_hold          = '0;
      seg_overflow     = 1'b0;
      rewritten_q.delete();
      mismatch_count_o = 0;
      in_flight_o      = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen.out_byte       = res_i.out_byte;
        seen.out_last       = res_i.out_last;
        seen.tcp_checksum   = res_i.tcp_checksum;
        seen.checksum_valid = res_i.checksum_valid;
        seen.too_long       = res_i.too_long;
        if (rewritten_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: result transfer with nothing outstanding: byte %h last %b",
                     $realtime, seen.out_byte, seen.out_last);
        end else begin
          want = rewritten_q.pop_front();
          if (seen !== want) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display({"%0t: mismatch byte/last/csum/valid/too_long ",
                        "exp %h/%b/%h/%b/%b got %h/%b/%h/%b/%b"}, $realtime,
                       want.out_byte, want.out_last, want.tcp_checksum,
                       want.checksum_valid, want.too_long,
                       seen.out_byte, seen.out_last, seen.tcp_checksum,
                       seen.checksum_valid, seen.too_long);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NEW_SRC_PORT:    src_port = cfg_wdata_i[15:0];
          CFG_NEW_DST_PORT:    dst_port = cfg_wdata_i[15:0];
          CFG_PSEUDO_SRC_ADDR: src_addr = cfg_wdata_i;
          CFG_PSEUDO_DST_ADDR: dst_addr = cfg_wdata_i;
          default: ;
        endcase
      end
      if (seg_i.valid && seg_i.ready)
        rewritten_q.push_back(rewrite_byte(seg_i.seg_byte, seg_i.is_last));
      in_flight_o = rewritten_q.size();
    end
  end

endmodule

### sim/tcp_port_rewrite_checksum_core_tb.sv
// Testbench top for the TCP port rewrite and checksum core.
// Drives segments and register writes with random idling and gives the verdict;
// checking is by tprc_checksum_checker. Uses tprc_pkg, tprc_if, the core, the checker.
module tcp_port_rewrite_checksum_core_tb;
  import tprc_pkg::*;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned StallLimit  = 2000;

  typedef logic [7:0] seg_bytes_t [$];
  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_PERIODIC} rx_mode_e;
  typedef enum {KEEP_BOTH, SWAP_SRC, SWAP_DST, SWAP_BOTH} port_mode_e;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  cfg_idx_e        cfg_idx;
  logic [CfgW-1:0] cfg_wdata;
  int unsigned     mismatch_count;
  int unsigned     in_flight;

  int unsigned burst_left = 0;
  bit          steady     = 1'b0;
  bit          hold_req   = 1'b0;
  bit          hold_done  = 1'b0;
  int unsigned hold_left  = 0;
  rx_mode_e    rx_mode    = RX_ALWAYS;
  int unsigned rx_left    = 0;

  tprc_in_if  seg_ch ();
  tprc_out_if res_ch ();

  tcp_port_rewrite_checksum_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_ch),
    .res_o       (res_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tprc_checksum_checker csum_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seg_i            (seg_ch),
    .res_i            (res_ch),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .in_flight_o      (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0:       return 16'hffff;
      1:       return 16'h0001;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return LoopbackAddr;
      default: return $urandom();
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        seg_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    seg_ch.valid    <= 1'b1;
    seg_ch.seg_byte <= b;
    seg_ch.is_last  <= last;
    do @(posedge clk_i); while (!seg_ch.ready);
    burst_left--;
  endtask

  task automatic send_bytes(input seg_bytes_t bytes);
    for (int k = 0; k < bytes.size(); k++)
      put_byte(bytes[k], k == bytes.size() - 1);
  endtask

  task automatic send_segment(input int unsigned len);
    seg_bytes_t q;
    repeat (len) q.push_back(8'($urandom_range(0, 255)));
    steady = ($urandom_range(0, 4) == 0);
    send_bytes(q);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (in_flight != 0);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [15:0] sp, input logic [15:0] dp,
                             input logic [31:0] sa, input logic [31:0] da);
    seg_ch.valid <= 1'b0;
    burst_left = 0;
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_put(CFG_NEW_SRC_PORT, {16'h0, sp});
    cfg_put(CFG_NEW_DST_PORT, {16'h0, dp});
    cfg_put(CFG_PSEUDO_SRC_ADDR, sa);
    cfg_put(CFG_PSEUDO_DST_ADDR, da);
    cfg_we <= 1'b0;
  endtask

  // receiver: random ready patterns, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 3));
          rx_left = $urandom_range(16, 160);
        end
        rx_left--;
        case (rx_mode)
          RX_ALWAYS: res_ch.ready <= 1'b1;
          RX_MOSTLY: res_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_HALF:   res_ch.ready <= 1'($urandom_range(0, 1));
          default:   res_ch.ready <= (rx_left % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((seg_ch.valid && seg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= StallLimit) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    seg_bytes_t  dq;
    int unsigned random_sent;
    int unsigned seg_no;
    int unsigned len;
    logic [15:0] sp;
    logic [15:0] dp;
    random_sent = 0;
    seg_no      = 0;
    rst_ni          <= 1'b0;
    seg_ch.valid    <= 1'b0;
    seg_ch.seg_byte <= 8'h00;
    seg_ch.is_last  <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_NEW_SRC_PORT;
    cfg_wdata       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: both ports zero, bytes pass through
    send_bytes('{8'h00, 8'hff});
    // destination only, zero addresses; sum folds to all ones so checksum is zero
    load_config(16'h0000, 16'h0001, 32'h0, 32'h0);
    send_bytes('{8'hff, 8'hf4, 8'haa, 8'h55});
    // source only, single odd byte
    load_config(16'h8000, 16'h0000, LoopbackAddr, 32'hffff_ffff);
    send_bytes('{8'h5a});
    // both ports and addresses at maximum, reaches the checksum field
    load_config(16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
    repeat (18) dq.push_back(8'hff);
    send_bytes(dq);

    while (random_sent < RandomItems) begin
      if (seg_no % 4 == 0) begin
        sp = pick_port();
        dp = pick_port();
        case (port_mode_e'($urandom_range(0, 3)))
          KEEP_BOTH: begin
            sp = 16'h0;
            dp = 16'h0;
          end
          SWAP_SRC: dp = 16'h0;
          SWAP_DST: sp = 16'h0;
          default: ;
        endcase
        load_config(sp, dp, pick_addr(), pick_addr());
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: len = $urandom_range(20, 60);
        7, 8:                len = $urandom_range(1, 19);
        default:             len = $urandom_range(61, 300);
      endcase
      send_segment(len);
      random_sent += len;
      seg_no++;
      if (random_sent > 300) hold_req <= 1'b1;
    end
    seg_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
